// ----- rtl/paat_pkg.sv -----
package paat_pkg;

    // Default structural sizes.
    localparam int RING_DEPTH_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths of the register set.
    localparam int SPAN_W   = 10;
    localparam int LIMIT_W  = 12;
    localparam int ZERO_W   = 16;
    localparam int OFFS_W   = 10;
    localparam int ANGLE_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [SPAN_W-1:0]  SPAN_RST  = 10'd360;
    localparam logic [LIMIT_W-1:0] LOWER_RST = 12'd500;
    localparam logic [LIMIT_W-1:0] RANGE_RST = 12'd1000;
    localparam logic [ZERO_W-1:0]  ZERO_RST  = 16'd1000;
    localparam logic [OFFS_W-1:0]  OFFS_RST  = 10'd179;

    // Value that the sample rings and the seen bounds start from.
    localparam int RING_FILL = 1000;

    // Rollover threshold: 10 * |sample - avg| > 7 * range.
    localparam int ROLL_NUM = 7;
    localparam int ROLL_DEN = 10;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPAN  = 3'd0,
        CFG_LOWER = 3'd1,
        CFG_RANGE = 3'd2,
        CFG_ZERO  = 3'd3,
        CFG_OFFS  = 3'd4
    } t_cfg_idx;

endpackage

// ----- rtl/pan_angle_autorange_tracker.sv -----
// Channel | Direction | Valid   | Stall   | Payload
// --------+-----------+---------+---------+-----------------------------------------------
// in      | to block  | i_valid | o_stall | i_req_type, i_raw_sample
// out     | from block| o_valid | i_stall | o_angle, o_filtered_value, o_recalibrated,
//         |           |         |         | o_refilled
// cfg     | to block  | i_cfg_we| (none)  | i_cfg_idx, i_cfg_data
//
// The rank pass ranks one ring entry per cycle against the whole ring, and one shared
// restoring divider retires one quotient bit per cycle, first for the modulus and then for
// the angle quotient. Reset is synchronous and active low; it clears the sequencer, the
// rings, the bounds, the settings and the output valid flag, but not the work registers or
// the held output data. The input is stalled for the whole time an item is being worked on.
// A finished result sits in the output register, and the next input transfer is already
// taken while it waits. A new result that finds the output register still stalled waits in
// the hand-off state.
module pan_angle_autorange_tracker
    import paat_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,   // must be a power of two
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [SAMPLE_BITS-1:0]        i_raw_sample,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ANGLE_W-1:0]     o_angle,
    output logic [SAMPLE_BITS-1:0]        o_filtered_value,
    output logic                          o_recalibrated,
    output logic                          o_refilled,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int IW    = $clog2(RING_DEPTH);
    localparam int CW    = IW + 1;                 // rank counts reach RING_DEPTH
    localparam int SUMW  = SB + IW;
    localparam int DW    = SB + SPAN_W;            // divider dividend width
    localparam int DCW   = $clog2(DW);
    localparam int LO_K  = RING_DEPTH / 2 - 2;
    localparam int HI_K  = RING_DEPTH / 2 + 1;

    localparam logic [SB-1:0]   FILL     = SB'(RING_FILL);
    localparam logic [SUMW-1:0] SUM_RST  = SUMW'(RING_FILL * RING_DEPTH);
    localparam logic [IW-1:0]   IDX_LAST = IW'(RING_DEPTH - 1);
    localparam logic [DCW-1:0]  DIV_LAST = DCW'(DW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RANK, S_BOUND, S_ROLL, S_MODSET, S_MOD, S_MODFIX, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state               r_state;
    logic [SB-1:0]        r_raw   [RING_DEPTH];
    logic [SB-1:0]        r_avg   [RING_DEPTH];
    logic [SUMW-1:0]      r_sum;
    logic [IW-1:0]        r_pos;
    logic [IW-1:0]        r_idx;
    logic [DCW-1:0]       r_cnt;
    logic [SB-1:0]        r_seen_upper, r_seen_lower;
    logic [SB-1:0]        r_work_lower, r_work_range;
    logic [ZERO_W-1:0]    r_work_zero;
    logic [SPAN_W-1:0]    r_span;
    logic [OFFS_W-1:0]    r_offs;
    logic [SB-1:0]        r_sample;
    logic [SB-1:0]        r_lo, r_hi;
    logic [SB-1:0]        r_rng;                   // range with zero taken as one
    logic [SB-1:0]        r_rem;
    logic [DW-1:0]        r_quo;
    logic                 r_neg;
    logic                 r_recal, r_refl;
    logic                 r_ovalid;
    logic signed [ANGLE_W-1:0] r_angle;
    logic [SB-1:0]        r_fval;
    logic                 r_orecal, r_orefl;

    // Rank of the current candidate against the whole raw ring.
    logic [SB-1:0]         cand;
    logic [RING_DEPTH-1:0] lt_vec, le_vec;
    logic [CW-1:0]         n_less, n_le;

    always_comb begin
        cand = r_raw[r_idx];
        for (int j = 0; j < RING_DEPTH; j++) begin
            lt_vec[j] = r_raw[j] <  cand;
            le_vec[j] = r_raw[j] <= cand;
        end
        n_less = CW'($countones(lt_vec));
        n_le   = CW'($countones(le_vec));
    end

    // Bound widening and recalibration test.
    logic [SB-1:0]     n_su, n_sl;
    logic              n_recal;
    logic [SB:0]       win_top;

    always_comb begin
        n_su = r_seen_upper;
        n_sl = r_seen_lower;
        if (r_hi > r_seen_upper) begin
            n_su = r_hi;
        end else if (r_lo < r_seen_lower) begin
            n_sl = r_lo;
        end
        win_top = {1'b0, r_work_range} + {1'b0, r_work_lower};
        n_recal = ({1'b0, n_su} > win_top) || (n_sl < r_work_lower);
    end

    // Average, rollover test and range.
    logic [SB-1:0]   avg, dev, eff_rng;
    logic            n_roll;

    always_comb begin
        avg     = SB'(r_sum >> IW);
        dev     = (r_sample > avg) ? r_sample - avg : avg - r_sample;
        eff_rng = (r_work_range == '0) ? SB'(1) : r_work_range;
        n_roll  = ((SB+4)'(dev) * (SB+4)'(ROLL_DEN)) > ((SB+4)'(eff_rng) * (SB+4)'(ROLL_NUM));
    end

    // Shared restoring divider step: one quotient bit per cycle.
    logic [SB:0]   d_shift;
    logic          d_ge;
    logic [SB-1:0] d_rem;

    always_comb begin
        d_shift = {r_rem, r_quo[DW-1]};
        d_ge    = d_shift >= {1'b0, r_rng};
        d_rem   = d_ge ? SB'(d_shift - {1'b0, r_rng}) : SB'(d_shift);
    end

    // Modulus correction and angle operands.
    logic [SB-1:0]      mod_val;
    logic [ZERO_W:0]    diff_mag;
    logic               diff_neg;
    logic [ANGLE_W-1:0] offs_ext;

    always_comb begin
        mod_val  = (r_neg && r_rem != '0) ? r_rng - r_rem : r_rem;
        diff_neg = (ZERO_W+1)'(avg) < (ZERO_W+1)'(r_work_zero);
        diff_mag = diff_neg ? (ZERO_W+1)'(r_work_zero) - (ZERO_W+1)'(avg)
                            : (ZERO_W+1)'(avg) - (ZERO_W+1)'(r_work_zero);
        offs_ext = {{(ANGLE_W-OFFS_W){r_offs[OFFS_W-1]}}, r_offs};
    end

    // The output register takes a new result only when it is empty or its old result leaves in the same cycle.
    logic out_load;

    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_raw[k] <= FILL;
                r_avg[k] <= FILL;
            end
            r_sum        <= SUM_RST;
            r_pos        <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_seen_upper <= FILL;
            r_seen_lower <= FILL;
            r_work_lower <= SB'(LOWER_RST);
            r_work_range <= SB'(RANGE_RST);
            r_work_zero  <= ZERO_RST;
            r_span       <= SPAN_RST;
            r_offs       <= OFFS_RST;
            r_recal      <= 1'b0;
            r_refl       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_ovalid <= out_load || (r_ovalid && i_stall);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPAN:  r_span       <= i_cfg_data[SPAN_W-1:0];
                    CFG_LOWER: r_work_lower <= SB'(i_cfg_data[LIMIT_W-1:0]);
                    CFG_RANGE: r_work_range <= SB'(i_cfg_data[LIMIT_W-1:0]);
                    CFG_ZERO:  r_work_zero  <= i_cfg_data;
                    CFG_OFFS:  r_offs       <= i_cfg_data[OFFS_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_recal  <= 1'b0;
                        r_refl   <= 1'b0;
                        r_sample <= i_raw_sample;
                        r_idx    <= '0;
                        if (i_req_type) begin
                            r_raw[r_pos] <= i_raw_sample;
                            r_state      <= S_RANK;
                        end else begin
                            r_state <= S_MODSET;
                        end
                    end
                end
                S_RANK: begin
                    // A candidate holds sorted place k when less <= k < less-or-equal.
                    if (n_less <= CW'(LO_K) && CW'(LO_K) < n_le) r_lo <= cand;
                    if (n_less <= CW'(HI_K) && CW'(HI_K) < n_le) r_hi <= cand;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) r_state <= S_BOUND;
                end
                S_BOUND: begin
                    r_seen_upper <= n_su;
                    r_seen_lower <= n_sl;
                    if (n_recal) begin
                        r_work_zero  <= ZERO_W'(r_work_zero - ZERO_W'(r_work_lower)
                                                + ZERO_W'(n_sl));
                        r_work_lower <= n_sl;
                        r_work_range <= n_su - n_sl;
                        r_recal      <= 1'b1;
                    end
                    r_sum        <= r_sum - SUMW'(r_avg[r_pos]) + SUMW'(r_sample);
                    r_avg[r_pos] <= r_sample;
                    r_pos        <= r_pos + 1'b1;
                    r_state      <= S_ROLL;
                end
                S_ROLL: begin
                    if (n_roll) begin
                        for (int k = 0; k < RING_DEPTH; k++) r_avg[k] <= r_sample;
                        r_sum  <= SUMW'(r_sample) << IW;
                        r_refl <= 1'b1;
                    end
                    r_state <= S_MODSET;
                end
                S_MODSET: begin
                    r_rng   <= eff_rng;
                    r_neg   <= diff_neg;
                    r_rem   <= '0;
                    r_quo   <= DW'(diff_mag);
                    r_cnt   <= '0;
                    r_state <= S_MOD;
                end
                S_MOD, S_DIV: begin
                    r_rem <= d_rem;
                    r_quo <= {r_quo[DW-2:0], d_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= (r_state == S_MOD) ? S_MODFIX : S_FIN;
                    end
                end
                S_MODFIX: begin
                    r_quo   <= DW'(r_span) * DW'(mod_val);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // The quotient, the average and the flags hold still while we wait.
                    if (out_load) begin
                        r_angle  <= $signed(ANGLE_W'(r_quo) - offs_ext);
                        r_fval   <= avg;
                        r_orecal <= r_recal;
                        r_orefl  <= r_refl;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_angle          = r_angle;
    assign o_filtered_value = r_fval;
    assign o_recalibrated   = r_orecal;
    assign o_refilled       = r_orefl;

    // The bounds only ever widen from a common start.
    a_seen_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_upper >= r_seen_lower)
        else $error("seen bounds crossed");

    // The divider never runs with a zero divisor.
    a_rng_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD || r_state == S_DIV) |-> r_rng != '0)
        else $error("divider divisor is zero");

    // A new result only appears on leaving the hand-off state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside hand-off");

    // Input is held off whenever an item is in flight.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input open while busy");

endmodule

// ----- test/paat_checker.sv -----
module paat_checker
    import paat_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_req_type,
    input  logic [11:0]               i_raw_sample,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [ANGLE_W-1:0]        i_angle,
    input  logic [11:0]               i_filtered_value,
    input  logic                      i_recalibrated,
    input  logic                      i_refilled,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_recal_seen,
    output int                        o_refill_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [11:0]        filtered;
        logic               recal;
        logic               refill;
    } pan_result_t;

    // Tracker state mirrored; the sums are plain integers that never wrap.
    int              raw_ring [16];
    int              avg_ring [16];
    int              avg_sum;
    int              ring_pos;
    int              seen_upper;
    int              seen_lower;
    int              work_lower;
    int              work_range;
    logic [15:0]     work_zero;
    int              span;
    logic [9:0]      offset;

    pan_result_t     pan_results_due [$];

    function automatic void refill_average(int v);
        for (int k = 0; k < 16; k++) avg_ring[k] = v;
        avg_sum = v * 16;
    endfunction

    function automatic pan_result_t track_pan_item(logic rt, logic [11:0] s);
        int          sorted [16];
        int          t, j, lo, hi, avg, rng, d, diff, ang;
        pan_result_t r;
        r = '0;
        if (rt) begin
            raw_ring[ring_pos] = s;
            for (int k = 0; k < 16; k++) sorted[k] = raw_ring[k];
            for (int k = 1; k < 16; k++) begin
                t = sorted[k];
                j = k;
                while (j > 0 && sorted[j-1] > t) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = t;
            end
            lo = sorted[6];
            hi = sorted[9];
            // A new maximum wins; the minimum is only looked at otherwise.
            if (hi > seen_upper) seen_upper = hi;
            else if (lo < seen_lower) seen_lower = lo;
            if (seen_upper > work_range + work_lower || seen_lower < work_lower) begin
                work_zero  = work_zero - 16'(work_lower) + 16'(seen_lower);
                work_lower = seen_lower;
                work_range = seen_upper - seen_lower;
                r.recal    = 1'b1;
            end
            avg_sum = avg_sum - avg_ring[ring_pos] + int'(s);
            avg_ring[ring_pos] = s;
            ring_pos = (ring_pos + 1) % 16;
            avg = avg_sum / 16;
            d = (int'(s) > avg) ? int'(s) - avg : avg - int'(s);
            if (d * 10 > ((work_range == 0) ? 1 : work_range) * 7) begin
                refill_average(s);
                r.refill = 1'b1;
            end
        end
        avg  = avg_sum / 16;
        rng  = (work_range == 0) ? 1 : work_range;
        diff = (avg - int'(work_zero)) % rng;
        if (diff < 0) diff += rng;
        ang = (span * diff) / rng - int'($signed(offset));
        r.angle    = ang[ANGLE_W-1:0];
        r.filtered = avg[11:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        pan_result_t exp_r;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) raw_ring[k] = RING_FILL;
            refill_average(RING_FILL);
            ring_pos   = 0;
            seen_upper = RING_FILL;
            seen_lower = RING_FILL;
            work_lower = LOWER_RST;
            work_range = RANGE_RST;
            work_zero  = ZERO_RST;
            span       = SPAN_RST;
            offset     = OFFS_RST;
            pan_results_due.delete();
            o_fail_count  <= 0;
            o_checked     <= 0;
            o_recal_seen  <= 0;
            o_refill_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPAN:  span = i_cfg_data[SPAN_W-1:0];
                    CFG_LOWER: work_lower = i_cfg_data[LIMIT_W-1:0];
                    CFG_RANGE: work_range = i_cfg_data[LIMIT_W-1:0];
                    CFG_ZERO:  work_zero = i_cfg_data;
                    CFG_OFFS:  offset = i_cfg_data[OFFS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                pan_results_due.push_back(track_pan_item(i_req_type, i_raw_sample));
            if (i_out_valid && !i_out_stall) begin
                if (pan_results_due.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    errs++;
                end else begin
                    exp_r = pan_results_due.pop_front();
                    o_checked     <= o_checked + 1;
                    o_recal_seen  <= o_recal_seen + int'(i_recalibrated);
                    o_refill_seen <= o_refill_seen + int'(i_refilled);
                    if (exp_r.angle !== i_angle) begin
                        $error("angle: expected %0d, got %0d",
                               $signed(exp_r.angle), $signed(i_angle));
                        errs++;
                    end
                    if (exp_r.filtered !== i_filtered_value) begin
                        $error("filtered_value: expected %0d, got %0d",
                               exp_r.filtered, i_filtered_value);
                        errs++;
                    end
                    if (exp_r.recal !== i_recalibrated) begin
                        $error("recalibrated: expected %0b, got %0b",
                               exp_r.recal, i_recalibrated);
                        errs++;
                    end
                    if (exp_r.refill !== i_refilled) begin
                        $error("refilled: expected %0b, got %0b", exp_r.refill, i_refilled);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
        o_pending <= pan_results_due.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Stimulus and verdict for the pan angle tracker. The checker module beside the block
// watches both channels and the configuration port, and it predicts every result.
module tb_top;
    import paat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // An index past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int                   CYCLE_LIMIT    = 1000000;
    localparam int                   HOLD_CYCLES    = 400;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_req_type;
    logic [11:0]               i_raw_sample;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [ANGLE_W-1:0] o_angle;
    logic [11:0]               o_filtered_value;
    logic                      o_recalibrated;
    logic                      o_refilled;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int   fail_count, pending, checked, recal_seen, refill_seen;
    int   cycles;
    logic sample_taken;     // an input transfer happened at the last rising edge
    bit   sender_noisy;     // sender inserts random gaps
    bit   receiver_noisy;   // receiver stalls at random
    bit   hold_go;          // asks the receiver for one long hold-off
    int   track_pos;        // center of the well-formed sample stream

    pan_angle_autorange_tracker dut (.*);

    paat_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_req_type      (i_req_type),
        .i_raw_sample    (i_raw_sample),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_angle         (o_angle),
        .i_filtered_value(o_filtered_value),
        .i_recalibrated  (o_recalibrated),
        .i_refilled      (o_refilled),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_recal_seen    (recal_seen),
        .o_refill_seen   (refill_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Transfer detection is registered at the rising edge and read at the falling edge,
    // so the sender never races the block's own update of o_stall.
    always @(posedge i_clk) sample_taken <= i_valid && !o_stall;

    // Receiver: random stalls, or one long hold-off counted here when asked for.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_go = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= receiver_noisy && ($urandom_range(0, 99) < 29);
            end
        end
    end

    // Every call starts and ends at a falling edge. Gaps go in front of the item.
    task automatic send_pan_item(input logic rt, input logic [11:0] s);
        while (sender_noisy && ($urandom_range(0, 99) < 29)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= rt;
        i_raw_sample <= s;
        do @(negedge i_clk); while (!sample_taken);
    endtask

    // Waits until every expected result has come back, with the input idle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly a slowly drifting sensor with small noise; now and then a wrap-around
    // jump or a sample anywhere, plus plain queries.
    task automatic send_random_items(input int n);
        int roll, s;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 18) begin
                send_pan_item(1'b0, 12'($urandom));
            end else if (roll < 26) begin
                s = $urandom_range(0, 4095);
                track_pos = s;
                send_pan_item(1'b1, 12'(s));
            end else begin
                track_pos = track_pos + $urandom_range(0, 80) - 30;
                if (track_pos > 4095) track_pos = track_pos - 4096;
                if (track_pos < 0) track_pos = track_pos + 4096;
                s = track_pos + $urandom_range(0, 40) - 20;
                s = (s < 0) ? 0 : (s > 4095) ? 4095 : s;
                send_pan_item(1'b1, 12'(s));
            end
        end
    endtask

    task automatic write_random_settings();
        write_reg(CFG_SPAN,  16'($urandom));
        write_reg(CFG_LOWER, 16'($urandom));
        write_reg(CFG_RANGE, 16'($urandom));
        write_reg(CFG_ZERO,  16'($urandom));
        write_reg(CFG_OFFS,  16'($urandom));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req_type     = 1'b0;
        i_raw_sample   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_SPAN;
        i_cfg_data     = '0;
        sender_noisy   = 1'b0;
        receiver_noisy = 1'b0;
        hold_go        = 1'b0;
        track_pos      = RING_FILL;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings: a query before any sample, the extremes
        // of the sample, alternating bit patterns and a few repeats.
        send_pan_item(1'b0, 12'hFFF);
        send_pan_item(1'b1, 12'd0);
        send_pan_item(1'b1, 12'hFFF);
        send_pan_item(1'b1, 12'hFFF);
        send_pan_item(1'b1, 12'd0);
        send_pan_item(1'b1, 12'hAAA);
        send_pan_item(1'b1, 12'h555);
        send_pan_item(1'b0, 12'h000);
        for (int k = 0; k < 6; k++) send_pan_item(1'b1, 12'd3000);
        send_pan_item(1'b0, 12'h555);
        drain_results();

        // Extreme settings: a span of 720, an offset of -360, zero range, an ignored index.
        write_reg(CFG_SPAN,  16'd720);
        write_reg(CFG_OFFS,  16'(-360));
        write_reg(CFG_RANGE, 16'd0);
        write_reg(CFG_LOWER, 16'd4095);
        write_reg(CFG_ZERO,  16'hFFFF);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        send_pan_item(1'b0, 12'd0);
        send_pan_item(1'b1, 12'd100);
        send_pan_item(1'b1, 12'd4000);
        send_pan_item(1'b0, 12'd0);
        drain_results();

        write_reg(CFG_SPAN,  16'd1);
        write_reg(CFG_OFFS,  16'd360);
        write_reg(CFG_RANGE, 16'd4095);
        write_reg(CFG_LOWER, 16'd0);
        write_reg(CFG_ZERO,  16'd0);
        send_pan_item(1'b1, 12'd2048);
        send_pan_item(1'b0, 12'd0);
        drain_results();

        // A stretch with no idling at all, on both sides.
        send_random_items(60);

        // The receiver holds off while items keep coming, so the block backs up.
        sender_noisy   = 1'b1;
        receiver_noisy = 1'b1;
        hold_go        = 1'b1;
        send_random_items(40);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                write_reg(CFG_SPAN,  16'd360);
                write_reg(CFG_LOWER, 16'd500);
                write_reg(CFG_RANGE, 16'd1000);
                write_reg(CFG_ZERO,  16'd1000);
                write_reg(CFG_OFFS,  16'd179);
            end else begin
                write_random_settings();
            end
            send_random_items(105);
            drain_results();
        end

        repeat (100) @(negedge i_clk);
        $display("Run covered %0d results: %0d recalibrations, %0d average refills,",
                 checked, recal_seen, refill_seen);
        $display("over default, extreme and random register settings.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog on the total run length.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
